@@ hdl/atbg_pkg.sv @@
// shared types and constants for the affine tiled background pixel block
// used by atbg_xform and the top module; depends on nothing
`default_nettype none

package atbg_pkg;

   // video memory size and the address width that follows from it
   localparam int VIDEO_BYTES = 65536;
   localparam int VA_W        = $clog2(VIDEO_BYTES);

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

   // field widths of the items and registers
   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 15;
   localparam int PIXEL_W   = 8;
   localparam int COLOR_W   = 15;
   localparam int CHAN_W    = 8;
   localparam int BYTE_W    = 8;
   localparam int STEP_W    = 16;
   localparam int ORIGIN_W  = 28;
   localparam int LAYER_W   = 16;
   localparam int CSR_W     = 28;
   localparam int CSR_IDX_W = 3;

   // affine datapath widths
   localparam int FRAC_BITS = 8;
   localparam int PROD_W    = 24;               // 8-bit unsigned times signed 16
   localparam int ACC_W     = ORIGIN_W + 1;     // origin plus two products
   localparam int SX_W      = ACC_W - FRAC_BITS;
   localparam int UX_W      = 10;               // largest background is 1024 pixels
   localparam int SUM_W     = 18;               // wide enough for any address sum

   // tile geometry
   localparam int TILE_PX_SHIFT        = 3;     // 8 pixels per tile side
   localparam int MIN_SIZE_TILES_SHIFT = 4;     // 16 tiles per side at size code 0
   localparam int MIN_SIZE_PX_SHIFT    = MIN_SIZE_TILES_SHIFT + TILE_PX_SHIFT;
   localparam int MAP_BLOCK_SHIFT      = 11;
   localparam int CHAR_BLOCK_SHIFT     = 14;

   // layer control fields
   localparam int LC_CHAR_LO = 2;
   localparam int LC_CHAR_HI = 3;
   localparam int LC_MAP_LO  = 8;
   localparam int LC_MAP_HI  = 12;
   localparam int LC_WRAP    = 13;
   localparam int LC_SIZE_LO = 14;
   localparam int LC_SIZE_HI = 15;

   localparam logic [STEP_W-1:0] STEP_UNITY = 16'h0100;

   typedef enum logic [CMD_W-1:0] {
      CMD_VIDEO_WRITE   = 2'd0,
      CMD_PALETTE_WRITE = 2'd1,
      CMD_RENDER        = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_X_PIXEL  = 3'd0,
      CSR_STEP_X_LINE   = 3'd1,
      CSR_STEP_Y_PIXEL  = 3'd2,
      CSR_STEP_Y_LINE   = 3'd3,
      CSR_ORIGIN_X      = 3'd4,
      CSR_ORIGIN_Y      = 3'd5,
      CSR_LAYER_CONTROL = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [ADDR_W-1:0]  address;
      logic [DATA_W-1:0]  data;
      logic [PIXEL_W-1:0] pixel_x;
      logic [PIXEL_W-1:0] pixel_line;
   } req_item_type;

   typedef struct packed {
      logic              opaque;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_item_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step_x_per_pixel;
      logic [STEP_W-1:0]   step_x_per_line;
      logic [STEP_W-1:0]   step_y_per_pixel;
      logic [STEP_W-1:0]   step_y_per_line;
      logic [ORIGIN_W-1:0] origin_x;
      logic [ORIGIN_W-1:0] origin_y;
      logic [LAYER_W-1:0]  layer_control;
   } cfg_type;

   // item leaving the transform, with its tilemap address ready for the read
   typedef struct packed {
      logic                     valid;
      logic [CMD_W-1:0]         command;
      logic [ADDR_W-1:0]        address;
      logic [DATA_W-1:0]        data;
      logic [VA_W-1:0]          tile_addr;
      logic [TILE_PX_SHIFT-1:0] fine_y;
      logic [TILE_PX_SHIFT-1:0] fine_x;
      logic                     outside;
   } xf_item_type;

endpackage

`default_nettype wire

@@ hdl/atbg_ram.sv @@
// generic single-port-write, single-port-read synchronous ram
// read data is registered and returns the old contents on a same-address write
`default_nettype none

module atbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/atbg_xform.sv @@
// affine transform stages: products, sums, then wrap or clip and tilemap address
// depends on atbg_pkg
`default_nettype none

module atbg_xform (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire atbg_pkg::req_item_type req_item,
   input  wire atbg_pkg::cfg_type      cfg,
   output atbg_pkg::xf_item_type       xf_item
);

   typedef struct packed {
      logic                           valid;
      logic [atbg_pkg::CMD_W-1:0]     command;
      logic [atbg_pkg::ADDR_W-1:0]    address;
      logic [atbg_pkg::DATA_W-1:0]    data;
      logic [atbg_pkg::PROD_W-1:0]    x_line_prod;
      logic [atbg_pkg::PROD_W-1:0]    x_pixel_prod;
      logic [atbg_pkg::PROD_W-1:0]    y_line_prod;
      logic [atbg_pkg::PROD_W-1:0]    y_pixel_prod;
   } prod_stage_type;

   typedef struct packed {
      logic                           valid;
      logic [atbg_pkg::CMD_W-1:0]     command;
      logic [atbg_pkg::ADDR_W-1:0]    address;
      logic [atbg_pkg::DATA_W-1:0]    data;
      logic [atbg_pkg::ACC_W-1:0]     ax;
      logic [atbg_pkg::ACC_W-1:0]     ay;
   } sum_stage_type;

   prod_stage_type prod_ff, prod_in;
   sum_stage_type  sum_ff, sum_in;

   logic signed [atbg_pkg::PROD_W:0] x_line_full, x_pixel_full, y_line_full, y_pixel_full;

   logic [atbg_pkg::SX_W-1:0]  sx, sy, size_px, size_mask;
   logic [1:0]                 size_code;
   logic [atbg_pkg::UX_W-1:0]  ux, uy;
   logic                       inside_x, inside_y, wrap;
   logic [atbg_pkg::SUM_W-1:0] map_base, row_off, map_sum;

   // stage one: the four products
   always_comb begin
      x_line_full  = $signed({1'b0, req_item.pixel_line}) * $signed(cfg.step_x_per_line);
      x_pixel_full = $signed({1'b0, req_item.pixel_x}) * $signed(cfg.step_x_per_pixel);
      y_line_full  = $signed({1'b0, req_item.pixel_line}) * $signed(cfg.step_y_per_line);
      y_pixel_full = $signed({1'b0, req_item.pixel_x}) * $signed(cfg.step_y_per_pixel);

      prod_in.valid        = accept;
      prod_in.command      = req_item.command;
      prod_in.address      = req_item.address;
      prod_in.data         = req_item.data;
      prod_in.x_line_prod  = x_line_full[atbg_pkg::PROD_W-1:0];
      prod_in.x_pixel_prod = x_pixel_full[atbg_pkg::PROD_W-1:0];
      prod_in.y_line_prod  = y_line_full[atbg_pkg::PROD_W-1:0];
      prod_in.y_pixel_prod = y_pixel_full[atbg_pkg::PROD_W-1:0];
   end

   // stage two: reference point plus both products, sign extended
   always_comb begin
      sum_in.valid   = prod_ff.valid;
      sum_in.command = prod_ff.command;
      sum_in.address = prod_ff.address;
      sum_in.data    = prod_ff.data;
      sum_in.ax =
         {{(atbg_pkg::ACC_W-atbg_pkg::ORIGIN_W){cfg.origin_x[atbg_pkg::ORIGIN_W-1]}},
          cfg.origin_x}
         + {{(atbg_pkg::ACC_W-atbg_pkg::PROD_W){prod_ff.x_line_prod[atbg_pkg::PROD_W-1]}},
            prod_ff.x_line_prod}
         + {{(atbg_pkg::ACC_W-atbg_pkg::PROD_W){prod_ff.x_pixel_prod[atbg_pkg::PROD_W-1]}},
            prod_ff.x_pixel_prod};
      sum_in.ay =
         {{(atbg_pkg::ACC_W-atbg_pkg::ORIGIN_W){cfg.origin_y[atbg_pkg::ORIGIN_W-1]}},
          cfg.origin_y}
         + {{(atbg_pkg::ACC_W-atbg_pkg::PROD_W){prod_ff.y_line_prod[atbg_pkg::PROD_W-1]}},
            prod_ff.y_line_prod}
         + {{(atbg_pkg::ACC_W-atbg_pkg::PROD_W){prod_ff.y_pixel_prod[atbg_pkg::PROD_W-1]}},
            prod_ff.y_pixel_prod};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
         sum_ff  <= '0;
      end else begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   // dropping the fraction of a two's complement value is a floor
   always_comb begin
      sx        = sum_ff.ax[atbg_pkg::ACC_W-1:atbg_pkg::FRAC_BITS];
      sy        = sum_ff.ay[atbg_pkg::ACC_W-1:atbg_pkg::FRAC_BITS];
      size_code = cfg.layer_control[atbg_pkg::LC_SIZE_HI:atbg_pkg::LC_SIZE_LO];
      wrap      = cfg.layer_control[atbg_pkg::LC_WRAP];
      size_px   = atbg_pkg::SX_W'(1) << (atbg_pkg::MIN_SIZE_PX_SHIFT + size_code);
      size_mask = size_px - atbg_pkg::SX_W'(1);

      ux = sx[atbg_pkg::UX_W-1:0] & size_mask[atbg_pkg::UX_W-1:0];
      uy = sy[atbg_pkg::UX_W-1:0] & size_mask[atbg_pkg::UX_W-1:0];

      inside_x = !sx[atbg_pkg::SX_W-1] && (sx < size_px);
      inside_y = !sy[atbg_pkg::SX_W-1] && (sy < size_px);

      map_base = atbg_pkg::SUM_W'(cfg.layer_control[atbg_pkg::LC_MAP_HI:atbg_pkg::LC_MAP_LO])
                 << atbg_pkg::MAP_BLOCK_SHIFT;
      row_off  = atbg_pkg::SUM_W'(uy[atbg_pkg::UX_W-1:atbg_pkg::TILE_PX_SHIFT])
                 << (atbg_pkg::MIN_SIZE_TILES_SHIFT + size_code);
      map_sum  = map_base + row_off
                 + atbg_pkg::SUM_W'(ux[atbg_pkg::UX_W-1:atbg_pkg::TILE_PX_SHIFT]);

      xf_item.valid     = sum_ff.valid;
      xf_item.command   = sum_ff.command;
      xf_item.address   = sum_ff.address;
      xf_item.data      = sum_ff.data;
      xf_item.tile_addr = map_sum[atbg_pkg::VA_W-1:0];
      xf_item.fine_y    = uy[atbg_pkg::TILE_PX_SHIFT-1:0];
      xf_item.fine_x    = ux[atbg_pkg::TILE_PX_SHIFT-1:0];
      xf_item.outside   = !wrap && !(inside_x && inside_y);
   end

endmodule

`default_nettype wire

@@ hdl/affine_tile_background_pixel.sv @@
// render item: result strobed on rsp_valid from the output register at the end of the pipe
// one item per clock, start taken every cycle outside reset; busy is high only during reset
// pipeline: two transform stages, tilemap read, texel read, palette read
// writes enter the same pipe, video bytes land with the texel read, palette with its read
// synchronous reset clears the pipe and loads the identity transform; memories keep contents
`default_nettype none

module affine_tile_background_pixel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire atbg_pkg::req_item_type              req_item,
   output logic                                     rsp_valid,
   output atbg_pkg::rsp_item_type                   rsp_item,
   input  wire logic                                csr_we,
   input  wire logic [atbg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [atbg_pkg::CSR_W-1:0]          csr_wdata
);

   typedef struct packed {
      logic                                 valid;
      logic [atbg_pkg::CMD_W-1:0]           command;
      logic [atbg_pkg::ADDR_W-1:0]          address;
      logic [atbg_pkg::DATA_W-1:0]          data;
      logic [atbg_pkg::TILE_PX_SHIFT-1:0]   fine_y;
      logic [atbg_pkg::TILE_PX_SHIFT-1:0]   fine_x;
      logic                                 outside;
      logic                                 fwd_hit;
      logic [atbg_pkg::BYTE_W-1:0]          fwd_tile;
   } texel_stage_type;

   typedef struct packed {
      logic                                 valid;
      logic [atbg_pkg::CMD_W-1:0]           command;
      logic [atbg_pkg::PAL_AW-1:0]          pal_idx;
      logic [atbg_pkg::COLOR_W-1:0]         color;
      logic                                 outside;
   } pal_stage_type;

   typedef struct packed {
      logic render;
      logic opaque;
   } color_stage_type;

   function automatic logic [atbg_pkg::CHAN_W-1:0] expand5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

   atbg_pkg::cfg_type      cfg_ff, cfg_in;
   atbg_pkg::xf_item_type  xf_item;
   texel_stage_type        tx_ff, tx_in;
   pal_stage_type          pal_ff, pal_in;
   color_stage_type        col_ff, col_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   atbg_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                               accept;
   logic                               vid_we;
   logic [atbg_pkg::SUM_W-1:0]         vid_addr_ext, texel_sum;
   logic [atbg_pkg::VA_W-1:0]          vid_wr_addr, texel_addr;
   logic [atbg_pkg::BYTE_W-1:0]        map_rd_data, texel_rd_data, tile;
   logic                               pal_we;
   logic [atbg_pkg::COLOR_W-1:0]       pal_rd_data;

   assign busy   = reset;
   assign accept = start && !busy;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            atbg_pkg::CSR_STEP_X_PIXEL: begin
               cfg_in.step_x_per_pixel = csr_wdata[atbg_pkg::STEP_W-1:0];
            end
            atbg_pkg::CSR_STEP_X_LINE: begin
               cfg_in.step_x_per_line = csr_wdata[atbg_pkg::STEP_W-1:0];
            end
            atbg_pkg::CSR_STEP_Y_PIXEL: begin
               cfg_in.step_y_per_pixel = csr_wdata[atbg_pkg::STEP_W-1:0];
            end
            atbg_pkg::CSR_STEP_Y_LINE: begin
               cfg_in.step_y_per_line = csr_wdata[atbg_pkg::STEP_W-1:0];
            end
            atbg_pkg::CSR_ORIGIN_X: begin
               cfg_in.origin_x = csr_wdata[atbg_pkg::ORIGIN_W-1:0];
            end
            atbg_pkg::CSR_ORIGIN_Y: begin
               cfg_in.origin_y = csr_wdata[atbg_pkg::ORIGIN_W-1:0];
            end
            atbg_pkg::CSR_LAYER_CONTROL: begin
               cfg_in.layer_control = csr_wdata[atbg_pkg::LAYER_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   atbg_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .xf_item  (xf_item)
   );

   // video writes commit in the texel stage
   always_comb begin
      vid_addr_ext = atbg_pkg::SUM_W'(tx_ff.address);
      vid_wr_addr  = vid_addr_ext[atbg_pkg::VA_W-1:0];
      vid_we       = tx_ff.valid && (tx_ff.command == atbg_pkg::CMD_VIDEO_WRITE);
   end

   // tilemap read goes out on the same edge as the write ahead of it lands and sees old data: forward it
   always_comb begin
      tx_in.valid    = xf_item.valid;
      tx_in.command  = xf_item.command;
      tx_in.address  = xf_item.address;
      tx_in.data     = xf_item.data;
      tx_in.fine_y   = xf_item.fine_y;
      tx_in.fine_x   = xf_item.fine_x;
      tx_in.outside  = xf_item.outside;
      tx_in.fwd_hit  = vid_we && (xf_item.tile_addr == vid_wr_addr);
      tx_in.fwd_tile = tx_ff.data[atbg_pkg::BYTE_W-1:0];
   end

   // two copies of video memory give the tilemap and texel reads a port each
   atbg_ram #(
      .WIDTH (atbg_pkg::BYTE_W),
      .DEPTH (atbg_pkg::VIDEO_BYTES)
   ) u_vram_map (
      .clock   (clock),
      .wr_en   (vid_we),
      .wr_addr (vid_wr_addr),
      .wr_data (tx_ff.data[atbg_pkg::BYTE_W-1:0]),
      .rd_addr (xf_item.tile_addr),
      .rd_data (map_rd_data)
   );

   always_comb begin
      tile       = tx_ff.fwd_hit ? tx_ff.fwd_tile : map_rd_data;
      texel_sum  = (atbg_pkg::SUM_W'(cfg_ff.layer_control[atbg_pkg::LC_CHAR_HI:atbg_pkg::LC_CHAR_LO])
                    << atbg_pkg::CHAR_BLOCK_SHIFT)
                   + atbg_pkg::SUM_W'({tile, tx_ff.fine_y, tx_ff.fine_x});
      texel_addr = texel_sum[atbg_pkg::VA_W-1:0];
   end

   atbg_ram #(
      .WIDTH (atbg_pkg::BYTE_W),
      .DEPTH (atbg_pkg::VIDEO_BYTES)
   ) u_vram_texel (
      .clock   (clock),
      .wr_en   (vid_we),
      .wr_addr (vid_wr_addr),
      .wr_data (tx_ff.data[atbg_pkg::BYTE_W-1:0]),
      .rd_addr (texel_addr),
      .rd_data (texel_rd_data)
   );

   always_comb begin
      pal_in.valid   = tx_ff.valid;
      pal_in.command = tx_ff.command;
      pal_in.pal_idx = tx_ff.address[atbg_pkg::PAL_AW-1:0];
      pal_in.color   = tx_ff.data;
      pal_in.outside = tx_ff.outside;
      pal_we         = pal_ff.valid && (pal_ff.command == atbg_pkg::CMD_PALETTE_WRITE);
   end

   atbg_ram #(
      .WIDTH (atbg_pkg::COLOR_W),
      .DEPTH (atbg_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_ff.pal_idx),
      .wr_data (pal_ff.color),
      .rd_addr (texel_rd_data),
      .rd_data (pal_rd_data)
   );

   // texel zero is transparent
   always_comb begin
      col_in.render = pal_ff.valid && (pal_ff.command == atbg_pkg::CMD_RENDER);
      col_in.opaque = !pal_ff.outside && (texel_rd_data != '0);
   end

   always_comb begin
      rsp_valid_in       = col_ff.render;
      rsp_item_in.opaque = col_ff.opaque;
      rsp_item_in.red    = col_ff.opaque ? expand5(pal_rd_data[4:0])   : '0;
      rsp_item_in.green  = col_ff.opaque ? expand5(pal_rd_data[9:5])   : '0;
      rsp_item_in.blue   = col_ff.opaque ? expand5(pal_rd_data[14:10]) : '0;
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         cfg_ff.step_x_per_pixel <= atbg_pkg::STEP_UNITY;
         cfg_ff.step_x_per_line  <= '0;
         cfg_ff.step_y_per_pixel <= '0;
         cfg_ff.step_y_per_line  <= atbg_pkg::STEP_UNITY;
         cfg_ff.origin_x         <= '0;
         cfg_ff.origin_y         <= '0;
         cfg_ff.layer_control    <= '0;
         tx_ff                   <= '0;
         pal_ff                  <= '0;
         col_ff                  <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         tx_ff        <= tx_in;
         pal_ff       <= pal_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // every result traces back to a render item accepted at the pipe's input
   a_rsp_has_render: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_item.command == atbg_pkg::CMD_RENDER), 6))
      else $error("result without a render item");

   // every render item gives its result on time
   a_render_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.command == atbg_pkg::CMD_RENDER)) |-> ##6 rsp_valid)
      else $error("render item lost");

   // transparent pixels carry no colour
   a_transparent_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.opaque)
         |-> (rsp_item.red == '0) && (rsp_item.green == '0) && (rsp_item.blue == '0))
      else $error("transparent pixel with colour");
`endif

endmodule

`default_nettype wire
